// File: src/sha256_stream_hasher_assert.svh
// ---------------------------------------------------------------------------
// sha256 stream hasher assertion macros
// implication checks on the rising clock, off while reset is asserted
// ---------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SHS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SHS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: src/shs_pkg.sv
// ---------------------------------------------------------------------------
// shs_pkg
// types, constants and round functions shared by the sha-256 stream hasher
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package shs_pkg;

	localparam int BLOCK_BYTES = 64;
	localparam int LENGTH_POS  = 56;
	localparam int ROUNDS      = 64;
	localparam int DIGEST_WORDS = 8;
	localparam int LEN_W       = 61;
	localparam logic [7:0] PAD_MARKER = 8'h80;

	localparam logic [31:0] IV_WORDS [DIGEST_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       message_end;
	} shs_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        final_word;
	} shs_out_t;

	typedef enum logic [1:0] {
		SRC_INPUT,
		SRC_MARKER,
		SRC_ZERO,
		SRC_LENGTH
	} shs_src_t;

	typedef struct packed {
		logic       put_byte;
		shs_src_t   byte_src;
		logic       init_work;
		logic       round_en;
		logic [5:0] round_idx;
		logic       fold;
		logic       load_out;
		logic [2:0] out_idx;
		logic       restart;
	} shs_cmd_t;

	typedef struct packed {
		logic fill_at_len;
		logic fill_at_last;
	} shs_stat_t;

	function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
		ror32 = (v >> n) | (v << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		big_sigma0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		big_sigma1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		small_sigma0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		small_sigma1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
	endfunction

endpackage

// File: src/shs_datapath.sv
// ---------------------------------------------------------------------------
// shs_datapath
// block buffer, message schedule, round registers and chaining value
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module shs_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        data_byte,
	input  shs_pkg::shs_cmd_t cmd,
	output shs_pkg::shs_stat_t stat,
	output shs_pkg::shs_out_t digest
);
	import shs_pkg::*;

	// buffer doubles as the 16-word schedule window, oldest word on top
	logic [511:0]       buf_q;
	logic [5:0]         fill_q;
	logic [LEN_W-1:0]   len_q;
	logic [31:0]        cv_q [DIGEST_WORDS];
	logic [31:0]        work_q [DIGEST_WORDS];
	shs_out_t           out_q;

	logic [63:0] bit_len;
	logic [7:0]  len_bytes [8];
	logic [7:0]  byte_in;
	logic [31:0] w_t, w_1, w_9, w_14, w_next;
	logic [31:0] t1, t2, ch, maj;

	assign bit_len = {len_q, 3'b000};

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			len_bytes[i] = bit_len[63 - 8*i -: 8];
		end
	end

	always_comb begin
		case (cmd.byte_src)
			SRC_INPUT:  byte_in = data_byte;
			SRC_MARKER: byte_in = PAD_MARKER;
			SRC_ZERO:   byte_in = 8'h00;
			SRC_LENGTH: byte_in = len_bytes[fill_q[2:0]];
			default:    byte_in = 8'h00;
		endcase
	end

	assign w_t  = buf_q[511:480];
	assign w_1  = buf_q[479:448];
	assign w_9  = buf_q[223:192];
	assign w_14 = buf_q[63:32];
	assign w_next = small_sigma1(w_14) + w_9 + small_sigma0(w_1) + w_t;

	assign ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
	assign t1  = work_q[7] + big_sigma1(work_q[4]) + ch + ROUND_K[cmd.round_idx] + w_t;
	assign t2  = big_sigma0(work_q[0]) + maj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q  <= '0;
			for (int i = 0; i < DIGEST_WORDS; i++) cv_q[i] <= IV_WORDS[i];
		end else if (cmd.restart) begin
			fill_q <= '0;
			len_q  <= '0;
			for (int i = 0; i < DIGEST_WORDS; i++) cv_q[i] <= IV_WORDS[i];
		end else begin
			if (cmd.put_byte) begin
				fill_q <= fill_q + 6'd1;
				if (cmd.byte_src == SRC_INPUT) len_q <= len_q + LEN_W'(1);
			end
			if (cmd.fold) begin
				for (int i = 0; i < DIGEST_WORDS; i++) cv_q[i] <= cv_q[i] + work_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put_byte) begin
			buf_q <= {buf_q[503:0], byte_in};
		end else if (cmd.round_en) begin
			buf_q <= {buf_q[479:0], w_next};
		end
		if (cmd.init_work) begin
			for (int i = 0; i < DIGEST_WORDS; i++) work_q[i] <= cv_q[i];
		end else if (cmd.round_en) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
		if (cmd.load_out) begin
			out_q.digest_word <= cv_q[cmd.out_idx];
			out_q.word_index  <= cmd.out_idx;
			out_q.final_word  <= (cmd.out_idx == 3'(DIGEST_WORDS - 1));
		end
	end

	assign stat.fill_at_len  = (fill_q == 6'(LENGTH_POS));
	assign stat.fill_at_last = (fill_q == 6'(BLOCK_BYTES - 1));
	assign digest = out_q;

endmodule

// File: src/shs_ctrl.sv
// ---------------------------------------------------------------------------
// shs_ctrl
// sequencer for absorbing, compression rounds, padding and digest output
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module shs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               byte_valid,
	input  logic               message_end,
	input  logic               digest_stall,
	input  shs_pkg::shs_stat_t stat,
	output logic               item_stall,
	output logic               digest_valid,
	output shs_pkg::shs_cmd_t  cmd
);
	import shs_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_ROUND = 5'b00010,
		S_FOLD  = 5'b00100,
		S_PAD   = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t     state_q, state_d;
	logic       close_q, marker_q, lenph_q, out_valid_q;
	logic [5:0] rnd_q;
	logic [2:0] idx_q;
	logic       accept;

	assign accept     = item_valid && (state_q == S_IDLE);
	assign item_stall = (state_q != S_IDLE);
	assign digest_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.byte_src  = SRC_INPUT;
		cmd.round_idx = rnd_q;
		cmd.out_idx   = idx_q;
		state_d       = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.put_byte  = byte_valid;
					cmd.init_work = byte_valid && stat.fill_at_last;
					if (byte_valid && stat.fill_at_last) state_d = S_ROUND;
					else if (message_end) state_d = S_PAD;
				end
			end
			S_ROUND: begin
				cmd.round_en = 1'b1;
				if (rnd_q == 6'(ROUNDS - 1)) state_d = S_FOLD;
			end
			S_FOLD: begin
				cmd.fold = 1'b1;
				if (lenph_q) state_d = S_OUT;
				else if (close_q) state_d = S_PAD;
				else state_d = S_IDLE;
			end
			S_PAD: begin
				cmd.put_byte = 1'b1;
				if (!marker_q) cmd.byte_src = SRC_MARKER;
				else if (!lenph_q && !stat.fill_at_len) cmd.byte_src = SRC_ZERO;
				else cmd.byte_src = SRC_LENGTH;
				cmd.init_work = stat.fill_at_last;
				if (stat.fill_at_last) state_d = S_ROUND;
			end
			S_OUT: begin
				cmd.load_out = !out_valid_q || !digest_stall;
				cmd.restart  = cmd.load_out && (idx_q == 3'(DIGEST_WORDS - 1));
				if (cmd.restart) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			close_q     <= 1'b0;
			marker_q    <= 1'b0;
			lenph_q     <= 1'b0;
			out_valid_q <= 1'b0;
			rnd_q       <= '0;
			idx_q       <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				close_q  <= message_end;
				marker_q <= 1'b0;
				lenph_q  <= 1'b0;
			end
			if (cmd.put_byte && cmd.byte_src == SRC_MARKER) marker_q <= 1'b1;
			if (cmd.put_byte && cmd.byte_src == SRC_LENGTH) lenph_q <= 1'b1;
			if (cmd.restart) begin
				close_q  <= 1'b0;
				marker_q <= 1'b0;
				lenph_q  <= 1'b0;
			end
			rnd_q <= cmd.round_en ? rnd_q + 6'd1 : '0;
			if (cmd.load_out) idx_q <= idx_q + 3'd1;
			// transaction on the digest side frees the output register
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!digest_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

// File: src/sha256_stream_hasher.sv
// ---------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream, digest out as eight big-endian words
// ---------------------------------------------------------------------------
// An ordinary byte is accepted in the idle state. The 64th byte of a block
// starts the compression: 64 rounds, one per cycle, and a fold of the result
// into the chaining value, during which the input is stalled. A close pads
// one byte a cycle up to the block end (plus a second compression when the
// length does not fit), then loads one digest word per cycle into the output
// register while the receiver does not stall, eight in all. Sustained
// throughput is set by the single round unit, which stalls the input.
`timescale 1ns / 1ps

module sha256_stream_hasher (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  shs_pkg::shs_in_t  item,
	output logic              digest_valid,
	input  logic              digest_stall,
	output shs_pkg::shs_out_t digest
);
	import shs_pkg::*;

	`include "sha256_stream_hasher_assert.svh"

	shs_cmd_t  cmd;
	shs_stat_t stat;

	shs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.byte_valid   (item.byte_valid),
		.message_end  (item.message_end),
		.digest_stall (digest_stall),
		.stat         (stat),
		.item_stall   (item_stall),
		.digest_valid (digest_valid),
		.cmd          (cmd)
	);

	shs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (item.data_byte),
		.cmd       (cmd),
		.stat      (stat),
		.digest    (digest)
	);

	// no transaction is taken while the round unit is busy
	`SHS_ASSERT_IMPLY(a_stall_in_round, clk, arst_n, cmd.round_en, item_stall)
	// last digest word is never followed directly by another word
	`SHS_ASSERT_NEXT(a_single_digest, clk, arst_n,
		digest_valid && !digest_stall && digest.final_word, !digest_valid)
	`SHS_ASSERT_IMPLY(a_final_index, clk, arst_n, digest_valid,
		digest.final_word == (digest.word_index == 3'd7))

endmodule

// File: tb/sv/tb_sha256_stream_hasher.sv
// ---------------------------------------------------------------------------
// tb_sha256_stream_hasher
// drives byte streams into the hasher and checks every digest word against
// a behavioral sha-256 kept in a small scoreboard class
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sha256_stream_hasher;
	import shs_pkg::*;

	class digest_board;
		logic [31:0] hash_state [8];
		logic [7:0]  blk [64];
		int          fill;
		logic [60:0] byte_count;
		shs_out_t    pending [$];
		int          errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			hash_state = IV_WORDS;
			fill = 0;
			byte_count = '0;
		endfunction

		function logic [31:0] rot(logic [31:0] v, int n);
			return (v >> n) | (v << (32 - n));
		endfunction

		function void run_block();
			logic [31:0] w [64];
			logic [31:0] r [8];
			logic [31:0] t1, t2, e, a, x, y;
			for (int i = 0; i < 16; i++)
				w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
			for (int i = 16; i < 64; i++) begin
				x = w[i-15];
				y = w[i-2];
				w[i] = w[i-16] + (rot(x, 7) ^ rot(x, 18) ^ (x >> 3)) + w[i-7]
					+ (rot(y, 17) ^ rot(y, 19) ^ (y >> 10));
			end
			r = hash_state;
			for (int i = 0; i < 64; i++) begin
				e = r[4];
				a = r[0];
				t1 = r[7] + (rot(e, 6) ^ rot(e, 11) ^ rot(e, 25)) + ((e & r[5]) ^ (~e & r[6]))
					+ ROUND_K[i] + w[i];
				t2 = (rot(a, 2) ^ rot(a, 13) ^ rot(a, 22)) + ((a & r[1]) ^ (a & r[2]) ^ (r[1] & r[2]));
				r[7] = r[6]; r[6] = r[5]; r[5] = e; r[4] = r[3] + t1;
				r[3] = r[2]; r[2] = r[1]; r[1] = a; r[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++)
				hash_state[i] += r[i];
		endfunction

		function void absorb(logic [7:0] b);
			blk[fill] = b;
			fill = (fill + 1) % 64;
			if (fill == 0)
				run_block();
		endfunction

		// note one accepted input transaction
		function void note_item(shs_in_t it);
			logic [63:0] bits;
			shs_out_t o;
			if (it.byte_valid) begin
				absorb(it.data_byte);
				byte_count = byte_count + 61'd1;
			end
			if (!it.message_end)
				return;
			bits = {byte_count, 3'b000};
			absorb(PAD_MARKER);
			while (fill != LENGTH_POS)
				absorb(8'h00);
			for (int i = 0; i < 8; i++)
				absorb(bits[63 - 8*i -: 8]);
			for (int i = 0; i < 8; i++) begin
				o.digest_word = hash_state[i];
				o.word_index = i[2:0];
				o.final_word = (i == 7);
				pending.push_back(o);
			end
			restart();
		endfunction

		function void report(string what);
			$display("mismatch: %s", what);
			errors++;
		endfunction

		function void check_word(shs_out_t got);
			shs_out_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected digest word %h", got));
				return;
			end
			want = pending.pop_front();
			if (got.digest_word !== want.digest_word)
				report($sformatf("word %0d digest %h want %h", want.word_index,
					got.digest_word, want.digest_word));
			if (got.word_index !== want.word_index)
				report($sformatf("index %0d want %0d", got.word_index, want.word_index));
			if (got.final_word !== want.final_word)
				report($sformatf("final flag %b want %b", got.final_word, want.final_word));
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     item_valid = 1'b0;
	logic     item_stall;
	shs_in_t  item = '0;
	logic     digest_valid;
	logic     digest_stall = 1'b1;
	shs_out_t digest;

	digest_board board = new();
	bit hold_off = 1'b0;
	bit stim_done = 1'b0;

	sha256_stream_hasher i_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.digest_valid(digest_valid), .digest_stall(digest_stall), .digest(digest)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// offer one transaction and wait until it is taken
	task automatic send_item(logic [7:0] b, logic bv, logic fin);
		item_valid <= 1'b1;
		item <= '{data_byte: b, byte_valid: bv, message_end: fin};
		do @(posedge clk); while (item_stall);
		board.note_item(item);
	endtask

	task automatic maybe_gap();
		int n;
		if ($urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 6);
			item_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_message(int len, bit gaps);
		bit join_last;
		join_last = (len > 0) && ($urandom_range(0, 1) == 1);
		for (int i = 0; i < len; i++) begin
			send_item(8'($urandom_range(0, 255)), 1'b1, join_last && (i == len - 1));
			if (gaps) maybe_gap();
		end
		// close either with the last byte or with a bare end marker
		if (!join_last) begin
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			if (gaps) maybe_gap();
		end
	endtask

	// receiver: bursts of stall, plus one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n)
			digest_stall <= 1'b1;
		else if (hold_off)
			digest_stall <= 1'b1;
		else if (stim_done)
			digest_stall <= ($urandom_range(0, 7) == 0);
		else
			digest_stall <= ($urandom_range(0, 2) == 0);
		if (arst_n && digest_valid && !digest_stall)
			board.check_word(digest);
	end

	initial begin
		#20ms;
		$display("sha256_stream_hasher test failed");
		$finish;
	end

	initial begin
		int len;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message, byte with close, edge values, byte-less items, abc
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h55, 1'b0, 1'b0);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'haa, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);

		// a full block from input bytes, then a padding-only block
		send_message(64, 1'b1);

		// long receiver hold-off while the sender keeps offering
		hold_off = 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				send_message(3, 1'b0);
				send_message(0, 1'b0);
				send_message(5, 1'b0);
			end
		join

		// random short messages
		for (int m = 0; m < 6; m++) begin
			len = $urandom_range(0, 6);
			if ($urandom_range(0, 4) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_message(len, 1'b1);
		end
		item_valid <= 1'b0;
		stim_done = 1'b1;

		fork
			wait (board.pending.size() == 0);
			begin
				repeat (200000) @(posedge clk);
				$display("sha256_stream_hasher test failed");
				$finish;
			end
		join_any
		repeat (200) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("sha256_stream_hasher test passed");
		else
			$display("sha256_stream_hasher test failed");
		$finish;
	end

endmodule
